// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/mwtg_pkg.sv -----
// Package for the tone generator: types, register codes, reset values,
// and the elaboration-time sine table function. No dependencies.
`timescale 1ns / 1ps

package mwtg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS      = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam int PHASE_W     = 32;
  localparam int COUNT_W     = 24;
  localparam int AMP_W       = 16;
  localparam int OUT_W       = 16;
  localparam int MAG_W       = 21;   // Q20 magnitude, 1.0 included
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int SCALE_SHIFT = 35;   // Q20 shape * Q15 gain

  localparam logic [MAG_W-1:0] ONE_Q20     = 21'h100000;
  localparam logic [63:0]      PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WAVEFORM     = 3'd0,
    CFG_PHASE_STEP   = 3'd1,
    CFG_AMPLITUDE    = 3'd2,
    CFG_CHANNEL_MODE = 3'd3,
    CFG_TONE_LENGTH  = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    CHAN_MONO   = 2'd0,
    CHAN_STEREO = 2'd1,
    CHAN_LEFT   = 2'd2,
    CHAN_RIGHT  = 2'd3
  } chan_mode_t;

  typedef struct packed {
    wave_t                waveform;
    logic [PHASE_W-1:0]   phase_step;
    logic [AMP_W-1:0]     amplitude;
    chan_mode_t           channel_mode;
    logic [COUNT_W-1:0]   tone_length;
  } cfg_t;

  // one queued tick: phase of the frame and its end-of-tone flag
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               last;
  } tick_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd42852281;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 16'd32768;
  localparam logic [COUNT_W-1:0] TONE_LENGTH_RST = 24'd44100;

  // two Q30 multiplies by x: t * x^2
  function automatic logic [63:0] series_step(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] m;
    m = (t * x) >> 30;
    return (m * x) >> 30;
  endfunction

  // quarter-wave sine entry k in Q20, Taylor series to x^15 in Q30
  function automatic logic [MAG_W-1:0] sine_q20(input int unsigned k,
                                               input int unsigned depth_log2);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x   = (PI_HALF_Q30 * 64'(k)) >> depth_log2;
    t   = x;
    sum = signed'(x);
    t   = series_step(t, x) / 64'd6;
    sum = sum - signed'(t);
    t   = series_step(t, x) / 64'd20;
    sum = sum + signed'(t);
    t   = series_step(t, x) / 64'd42;
    sum = sum - signed'(t);
    t   = series_step(t, x) / 64'd72;
    sum = sum + signed'(t);
    t   = series_step(t, x) / 64'd110;
    sum = sum - signed'(t);
    t   = series_step(t, x) / 64'd156;
    sum = sum + signed'(t);
    t   = series_step(t, x) / 64'd210;
    sum = sum - signed'(t);
    if (sum <= 64'sd0) begin
      return '0;
    end
    r = (64'(sum) + 64'd512) >> 10;
    if (r > 64'(ONE_Q20)) begin
      r = 64'(ONE_Q20);
    end
    return r[MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/mwtg_queue.sv -----
// Small tick queue between the phase front end and the waveform back end.
// Depends on mwtg_pkg (tick_t, queue_stat_t).
`timescale 1ns / 1ps

module mwtg_queue #(
  parameter int DEPTH = mwtg_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  mwtg_pkg::tick_t       push_data,
  output logic                  push_stall,
  output logic                  pop_valid,
  output mwtg_pkg::tick_t       pop_data,
  input  logic                  pop_en,
  output mwtg_pkg::queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mwtg_pkg::tick_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             push_fire;
  logic             pop_fire;

  always_comb begin
    stat.full  = (count == CNT_W'(DEPTH));
    stat.empty = (count == '0);
    push_stall = stat.full;
    pop_valid  = !stat.empty;
    pop_data   = mem[rd_ptr];
    push_fire  = push_valid && !stat.full;
    pop_fire   = pop_en && !stat.empty;
    count_next = count;
    if (push_fire && !pop_fire) begin
      count_next = count + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/mwtg_front.sv -----
// Front end: takes tick beats, keeps the phase accumulator and sample
// counter, and pushes phase plus end-of-tone flag. Depends on mwtg_pkg.
`timescale 1ns / 1ps

module mwtg_front (
  input  logic            clk,
  input  logic            rst,
  input  mwtg_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            restart,
  output logic            push_valid,
  input  logic            push_stall,
  output mwtg_pkg::tick_t push
);

  logic [mwtg_pkg::PHASE_W-1:0] phase;
  logic [mwtg_pkg::PHASE_W-1:0] phase_next;
  logic [mwtg_pkg::COUNT_W-1:0] sample_index;
  logic [mwtg_pkg::COUNT_W-1:0] sample_index_next;
  logic [mwtg_pkg::PHASE_W-1:0] cur_phase;
  logic [mwtg_pkg::COUNT_W-1:0] cur_index;
  logic                         is_last;
  logic                         fire;

  always_comb begin
    cur_phase  = restart ? '0 : phase;
    cur_index  = restart ? '0 : sample_index;
    // zero length acts as one: every frame ends the tone
    is_last    = (cfg.tone_length == '0) ||
                 (cur_index >= (cfg.tone_length - mwtg_pkg::COUNT_W'(1)));
    push.phase = cur_phase;
    push.last  = is_last;
    push_valid = in_valid;
    in_stall   = push_stall;
    fire       = in_valid && !push_stall;

    phase_next        = phase;
    sample_index_next = sample_index;
    if (fire) begin
      if (is_last) begin
        phase_next        = '0;
        sample_index_next = '0;
      end else begin
        phase_next        = cur_phase + cfg.phase_step;
        sample_index_next = cur_index + mwtg_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      sample_index <= '0;
    end else begin
      phase        <= phase_next;
      sample_index <= sample_index_next;
    end
  end

endmodule

// ----- rtl/mwtg_back.sv -----
// Back end: pipeline from phase to scaled, routed sample frame, with the
// sine ROM and the output register. Depends on mwtg_pkg.
`timescale 1ns / 1ps

module mwtg_back #(
  parameter int SINE_TABLE_DEPTH = mwtg_pkg::SINE_TABLE_DEPTH,
  parameter int SAMPLE_BITS      = mwtg_pkg::SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mwtg_pkg::cfg_t                      cfg,
  input  logic                                pop_valid,
  input  mwtg_pkg::tick_t                     pop_data,
  output logic                                pop_en,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mwtg_pkg::OUT_W-1:0]   left_sample,
  output logic signed [mwtg_pkg::OUT_W-1:0]   right_sample,
  output logic                                last
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int MAG_W = mwtg_pkg::MAG_W;
  localparam int K_W   = SAMPLE_BITS - 1;
  localparam int P1_W  = MAG_W + mwtg_pkg::AMP_W;
  localparam int P2_W  = P1_W + K_W;
  localparam int V_W   = P2_W - mwtg_pkg::SCALE_SHIFT;
  localparam int RES_W = ((SAMPLE_BITS > mwtg_pkg::OUT_W) ? SAMPLE_BITS : mwtg_pkg::OUT_W) + 1;
  localparam int OUT_W = mwtg_pkg::OUT_W;

  localparam logic [K_W-1:0] FULL    = {K_W{1'b1}};
  localparam logic [K_W-1:0] FULL_M1 = FULL - K_W'(1);
  localparam logic [V_W-1:0] LIM_POS = V_W'(FULL);
  localparam logic [V_W-1:0] LIM_NEG = V_W'(FULL) + V_W'(1);

  // quarter-wave sine, constant contents
  logic [MAG_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = mwtg_pkg::sine_q20(g, IDX_W);
  end

  logic en;

  // stage 1: popped tick
  logic                         s1_valid;
  logic [mwtg_pkg::PHASE_W-1:0] s1_phase;
  logic                         s1_last;
  logic [29:0]                  s1_pos;
  logic [29:0]                  s1_mir;
  logic [IDX_W-1:0]             s1_idx;
  logic [30:0]                  s1_tri_diff;
  logic [MAG_W-1:0]             s1_tri;
  logic [MAG_W-1:0]             s1_saw;
  logic [MAG_W-1:0]             s1_mag;
  logic                         s1_neg;
  logic                         s1_kmin;
  logic                         s1_use_sine;

  // stage 2: shape magnitude
  logic             s2_valid;
  logic [MAG_W-1:0] s2_mag;
  logic [MAG_W-1:0] s2_sine;
  logic             s2_use_sine;
  logic             s2_neg;
  logic             s2_kmin;
  logic             s2_last;
  logic [MAG_W-1:0] s2_sel;

  // stage 3: shape times gain
  logic            s3_valid;
  logic [P1_W-1:0] s3_prod;
  logic            s3_neg;
  logic            s3_kmin;
  logic            s3_last;
  logic [K_W-1:0]  s3_k;

  // stage 4: times full scale
  logic             s4_valid;
  logic [P2_W-1:0]  s4_prod;
  logic             s4_neg;
  logic             s4_last;
  logic [V_W-1:0]   s4_v;
  logic [V_W-1:0]   s4_sat;
  logic [RES_W-1:0] s4_res;
  logic [OUT_W-1:0] s4_sample;

  assign en     = !out_valid || !out_stall;
  assign pop_en = en && pop_valid;

  always_comb begin
    s1_pos      = s1_phase[29:0];
    s1_mir      = s1_phase[30] ? ~s1_pos : s1_pos;
    s1_idx      = s1_mir[29 -: IDX_W];
    s1_tri_diff = 31'h4000_0000 - 31'(s1_pos);
    s1_tri      = s1_phase[30] ? s1_tri_diff[30:10] : {1'b0, s1_pos[29:10]};
    s1_saw      = s1_phase[31] ? {1'b0, s1_phase[30:11]}
                               : mwtg_pkg::ONE_Q20 - s1_phase[31:11];
    s1_mag      = '0;
    s1_neg      = s1_phase[31];
    s1_kmin     = 1'b0;
    s1_use_sine = 1'b0;
    case (cfg.waveform)
      mwtg_pkg::WAVE_SINE: begin
        s1_use_sine = 1'b1;
      end
      mwtg_pkg::WAVE_TRIANGLE: begin
        s1_mag = s1_tri;
      end
      mwtg_pkg::WAVE_SQUARE: begin
        s1_mag  = mwtg_pkg::ONE_Q20;
        s1_kmin = !s1_phase[31];
      end
      mwtg_pkg::WAVE_SAW: begin
        s1_mag = s1_saw;
        s1_neg = !s1_phase[31];
      end
      default: begin
        s1_mag = '0;
      end
    endcase
  end

  always_comb begin
    s2_sel = s2_use_sine ? s2_sine : s2_mag;
    s3_k   = s3_kmin ? FULL_M1 : FULL;
    s4_v   = s4_prod[P2_W-1:mwtg_pkg::SCALE_SHIFT];
    if (s4_neg) begin
      s4_sat = (s4_v > LIM_NEG) ? LIM_NEG : s4_v;
      s4_res = RES_W'(0) - RES_W'(s4_sat);
    end else begin
      s4_sat = (s4_v > LIM_POS) ? LIM_POS : s4_v;
      s4_res = RES_W'(s4_sat);
    end
    s4_sample = s4_res[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_phase    <= pop_data.phase;
      s1_last     <= pop_data.last;

      s2_sine     <= sine_rom[s1_idx];
      s2_mag      <= s1_mag;
      s2_use_sine <= s1_use_sine;
      s2_neg      <= s1_neg;
      s2_kmin     <= s1_kmin;
      s2_last     <= s1_last;

      s3_prod     <= P1_W'(s2_sel) * P1_W'(cfg.amplitude);
      s3_neg      <= s2_neg;
      s3_kmin     <= s2_kmin;
      s3_last     <= s2_last;

      s4_prod     <= P2_W'(s3_prod) * P2_W'(s3_k);
      s4_neg      <= s3_neg;
      s4_last     <= s3_last;

      last        <= s4_last;
      case (cfg.channel_mode)
        mwtg_pkg::CHAN_STEREO: begin
          left_sample  <= s4_sample;
          right_sample <= s4_sample;
        end
        mwtg_pkg::CHAN_RIGHT: begin
          left_sample  <= '0;
          right_sample <= s4_sample;
        end
        default: begin
          left_sample  <= s4_sample;
          right_sample <= '0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/multi_waveform_tone_generator.sv -----
// Top level of the tone generator: config registers, front end, tick queue,
// back end and checks. Depends on mwtg_pkg, mwtg_front, mwtg_queue, mwtg_back.
//
//   channel  | direction | handshake            | beat payload
//   ---------+-----------+----------------------+-------------------------------------
//   in       | sink      | in_valid / in_stall  | restart
//   out      | source    | out_valid / out_stall| left_sample, right_sample, last
//   cfg      | sink      | cfg_write            | cfg_index, cfg_data
//
// One tick beat in and one frame beat out per clock, sustained while out_stall is low.
// A frame passes through queue slot, tick register, sine ROM read, gain multiply,
// full-scale multiply, then saturate into the output register.
// rst (synchronous) clears phase, sample counter, queue and valid bits and loads
// the register defaults. A stalled output freezes the back pipeline; the queue
// keeps taking ticks until full, then in_stall rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_waveform_tone_generator #(
  parameter int SINE_TABLE_DEPTH = mwtg_pkg::SINE_TABLE_DEPTH,
  parameter int SAMPLE_BITS      = mwtg_pkg::SAMPLE_BITS,
  parameter int QUEUE_DEPTH      = mwtg_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mwtg_pkg::OUT_W-1:0]    left_sample,
  output logic signed [mwtg_pkg::OUT_W-1:0]    right_sample,
  output logic                                 last,
  input  logic                                 cfg_write,
  input  logic [mwtg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwtg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mwtg_pkg::cfg_t        cfg;
  mwtg_pkg::tick_t       push;
  mwtg_pkg::tick_t       pop_data;
  mwtg_pkg::queue_stat_t q_stat;
  logic                  push_valid;
  logic                  push_stall;
  logic                  pop_valid;
  logic                  pop_en;
  logic                  in_fire;

  assign in_fire = in_valid && !in_stall;

  // register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform     <= mwtg_pkg::WAVE_SINE;
      cfg.phase_step   <= mwtg_pkg::PHASE_STEP_RST;
      cfg.amplitude    <= mwtg_pkg::AMPLITUDE_RST;
      cfg.channel_mode <= mwtg_pkg::CHAN_MONO;
      cfg.tone_length  <= mwtg_pkg::TONE_LENGTH_RST;
    end else if (cfg_write) begin
      case (mwtg_pkg::cfg_index_t'(cfg_index))
        mwtg_pkg::CFG_WAVEFORM: begin
          cfg.waveform <= mwtg_pkg::wave_t'(cfg_data[1:0]);
        end
        mwtg_pkg::CFG_PHASE_STEP: begin
          cfg.phase_step <= cfg_data[mwtg_pkg::PHASE_W-1:0];
        end
        mwtg_pkg::CFG_AMPLITUDE: begin
          cfg.amplitude <= cfg_data[mwtg_pkg::AMP_W-1:0];
        end
        mwtg_pkg::CFG_CHANNEL_MODE: begin
          cfg.channel_mode <= mwtg_pkg::chan_mode_t'(cfg_data[1:0]);
        end
        mwtg_pkg::CFG_TONE_LENGTH: begin
          cfg.tone_length <= cfg_data[mwtg_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // phase accumulator and tone counter
  mwtg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push       (push)
  );

  mwtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push),
    .push_stall (push_stall),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_en     (pop_en),
    .stat       (q_stat)
  );

  // waveform shaping, scaling and channel routing
  mwtg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_data     (pop_data),
    .pop_en       (pop_en),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last         (last)
  );

  // tone wraps: the tick after an end-of-tone tick starts at phase zero
  `ASSERT_NEXT(a_wrap_phase, clk, rst, in_fire && push.last, !in_valid || push.phase == '0, "phase not cleared after last frame")
  // after a restart the next tick sits exactly one step in
  `ASSERT_NEXT(a_restart_step, clk, rst, in_fire && restart && !push.last, !in_valid || restart || push.phase == $past(cfg.phase_step), "phase step lost after restart")
  // queue status flags are exclusive
  `ASSERT_IMPLY(a_queue_flags, clk, rst, q_stat.full, !q_stat.empty && in_stall, "queue full and empty at once")

endmodule

// ----- tb/multi_waveform_tone_generator_tb.sv -----
// Self-checking testbench for multi_waveform_tone_generator: tick beats in, frame
// beats out, each frame checked against a local phase-accumulator predictor.
// Depends on mwtg_pkg and the tone generator RTL; nothing else.
`timescale 1ns / 1ps

module multi_waveform_tone_generator_tb;
  import mwtg_pkg::*;

  // full-scale sample value, 2^(SAMPLE_BITS-1) - 1
  localparam logic [63:0] FULL_SCALE  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  // settle time after the last frame, a little margin on top of the frame path
  localparam int          SETTLE_CYC  = 10;
  // cycles with no beat on either side before we call it a hang; the longest
  // legal quiet stretch is the receiver hold-off plus a sender gap
  localparam int          QUIET_LIMIT = 2000;
  localparam int          HOLD_CYC    = 300;

  // one expected output frame
  typedef struct packed {
    logic [OUT_W-1:0] lsamp;
    logic [OUT_W-1:0] rsamp;
    logic             eot;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input side
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   restart   = 1'b0;
  // output side
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [OUT_W-1:0] left_sample;
  logic signed [OUT_W-1:0] right_sample;
  logic                   last;
  // register write port
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // predictor state: registers as last written, phase and frame counter
  cfg_t             cur_cfg;
  logic [PHASE_W-1:0] tone_phase;
  logic [COUNT_W-1:0] frame_cnt;
  logic [MAG_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  // frames predicted at tick acceptance, oldest first
  frame_t frames_due [$];

  int  errors       = 0;
  int  quiet_cycles = 0;
  // idling controls: sender gaps, receiver stalls, long receiver hold-off
  bit  tx_idle_en   = 1'b0;
  bit  rx_idle_en   = 1'b0;
  int  hold_left    = 0;
  int  stall_left   = 0;

  always #5 clk = ~clk;

  multi_waveform_tone_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // quarter-wave sine entry in Q20: Q30 Taylor series to x^15, each term
  // truncated, then rounded to nearest in Q20 and capped at 1.0
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        t;
    logic [63:0]        r;
    logic signed [63:0] acc;
    x   = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    t   = x;
    acc = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - signed'(t);
      end else begin
        acc = acc + signed'(t);
      end
    end
    if (acc <= 0) begin
      return '0;
    end
    r = (64'(acc) + 64'd512) >> 10;
    if (r > 64'(ONE_Q20)) begin
      r = 64'(ONE_Q20);
    end
    return r[MAG_W-1:0];
  endfunction

  // magnitude * gain * full scale, truncated toward zero, saturated, signed
  function automatic logic [OUT_W-1:0] scale_to_field(input logic [63:0] mag,
                                                      input logic [63:0] mult,
                                                      input bit          neg);
    logic [63:0] v;
    v = (mag * 64'(cur_cfg.amplitude) * mult) >> SCALE_SHIFT;
    if (neg) begin
      if (v > FULL_SCALE + 64'd1) begin
        v = FULL_SCALE + 64'd1;
      end
      v = 64'd0 - v;
    end else if (v > FULL_SCALE) begin
      v = FULL_SCALE;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] shape_sample(input logic [PHASE_W-1:0] ph);
    logic [1:0]  quad;
    logic [29:0] pos;
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] h;
    bit          neg;
    quad = ph[31:30];
    pos  = ph[29:0];
    neg  = quad[1];
    case (cur_cfg.waveform)
      WAVE_SINE: begin
        // odd quadrants run the table backwards
        p   = quad[0] ? 64'(30'h3FFF_FFFF - pos) : 64'(pos);
        idx = (p * 64'(SINE_TABLE_DEPTH)) >> 30;
        if (idx >= 64'(SINE_TABLE_DEPTH)) begin
          idx = 64'(SINE_TABLE_DEPTH - 1);
        end
        return scale_to_field(64'(sine_rom[int'(idx)]), FULL_SCALE, neg);
      end
      WAVE_TRIANGLE: begin
        p = quad[0] ? (64'h4000_0000 - 64'(pos)) >> 10 : 64'(pos) >> 10;
        return scale_to_field(p, FULL_SCALE, neg);
      end
      WAVE_SQUARE: begin
        // positive half is one count short of full scale
        if (ph[31]) begin
          return scale_to_field(64'(ONE_Q20), FULL_SCALE, 1'b1);
        end
        return scale_to_field(64'(ONE_Q20), FULL_SCALE - 64'd1, 1'b0);
      end
      default: begin
        // rising saw, 2p - 1 over one period
        h = 64'(ph >> 11);
        if (h >= 64'(ONE_Q20)) begin
          return scale_to_field(h - 64'(ONE_Q20), FULL_SCALE, 1'b0);
        end
        return scale_to_field(64'(ONE_Q20) - h, FULL_SCALE, 1'b1);
      end
    endcase
  endfunction

  // frame for one accepted tick; advances phase and counter
  function automatic frame_t next_frame(input bit rs);
    frame_t           f;
    logic [OUT_W-1:0] s;
    logic [31:0]      len;
    bit               fin;
    if (rs) begin
      tone_phase = '0;
      frame_cnt  = '0;
    end
    s = shape_sample(tone_phase);
    case (cur_cfg.channel_mode)
      CHAN_STEREO: begin
        f.lsamp = s;
        f.rsamp = s;
      end
      CHAN_RIGHT: begin
        f.lsamp = '0;
        f.rsamp = s;
      end
      default: begin
        f.lsamp = s;
        f.rsamp = '0;
      end
    endcase
    // zero length acts as one; a lowered length ends the tone at once
    len   = (cur_cfg.tone_length == '0) ? 32'd1 : 32'(cur_cfg.tone_length);
    fin   = 32'(frame_cnt) >= len - 32'd1;
    f.eot = fin;
    if (fin) begin
      tone_phase = '0;
      frame_cnt  = '0;
    end else begin
      tone_phase = tone_phase + cur_cfg.phase_step;
      frame_cnt  = frame_cnt + COUNT_W'(1);
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // offer one tick beat and wait for it to be taken; valid stays high on return
  // so back-to-back beats never lower and raise it in one step
  task automatic send_tick(input bit rs);
    int unsigned gap;
    frame_t      f;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    f = next_frame(rs);
    frames_due.push_back(f);
  endtask

  // drop valid, wait for every expected frame plus pipeline settle time
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // write all five registers back to back; only called with the block idle
  task automatic apply_cfg(input cfg_t c);
    put_reg(CFG_WAVEFORM,     CFG_DATA_W'(c.waveform));
    put_reg(CFG_PHASE_STEP,   CFG_DATA_W'(c.phase_step));
    put_reg(CFG_AMPLITUDE,    CFG_DATA_W'(c.amplitude));
    put_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(c.channel_mode));
    put_reg(CFG_TONE_LENGTH,  CFG_DATA_W'(c.tone_length));
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_cfg = c;
  endtask

  // random settings weighted toward the edges; short tones so last shows up
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.waveform = wave_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       c.phase_step = '0;
      1:       c.phase_step = '1;
      2:       c.phase_step = $urandom_range(1, 4096);
      default: c.phase_step = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0:       c.amplitude = '0;
      1:       c.amplitude = AMPLITUDE_RST;
      2:       c.amplitude = '1;
      3:       c.amplitude = AMP_W'($urandom_range(32769, 65535));
      default: c.amplitude = AMP_W'($urandom_range(1, 32768));
    endcase
    c.channel_mode = chan_mode_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       c.tone_length = '0;
      1:       c.tone_length = '1;
      2:       c.tone_length = COUNT_W'($urandom_range(1000, 24'hFF_FFFF));
      default: c.tone_length = COUNT_W'($urandom_range(1, 48));
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // register defaults straight out of reset, one mid-stream restart
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // quarter-turn steps land on each quadrant; one waveform and one channel
  // mode per pass, gain at full scale, zero and overdriven
  task automatic test_waveform_shapes();
    cfg_t             c;
    logic [AMP_W-1:0] gains [4];
    gains = '{AMPLITUDE_RST, 16'd0, 16'hFFFF, AMPLITUDE_RST};
    for (int w = 0; w < 4; w++) begin
      c.waveform     = wave_t'(w);
      c.phase_step   = 32'h4000_0000;
      c.amplitude    = gains[w];
      c.channel_mode = chan_mode_t'(w);
      c.tone_length  = 24'd16;
      wait_idle();
      apply_cfg(c);
      for (int i = 0; i < 4; i++) begin
        send_tick(i == 0);
      end
    end
  endtask

  // zero length (every frame last), then a length cut below the running count
  task automatic test_tone_length_edges();
    cfg_t c;
    c              = cur_cfg;
    c.waveform     = WAVE_SAW;
    c.phase_step   = 32'h1234_5678;
    c.amplitude    = AMPLITUDE_RST;
    c.channel_mode = CHAN_STEREO;
    c.tone_length  = '0;
    wait_idle();
    apply_cfg(c);
    repeat (3) send_tick(1'b0);
    c.tone_length = 24'd100;
    wait_idle();
    apply_cfg(c);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    // counter is at 6 now, so the next frame must end the tone
    c.tone_length = 24'd3;
    wait_idle();
    apply_cfg(c);
    repeat (3) send_tick(1'b0);
  endtask

  // receiver holds off long enough for the queue to fill and in_stall to rise,
  // sender keeps offering; the sender pauses until all drains, then a second burst runs with random idling
  task automatic test_backpressure();
    cfg_t c;
    c             = random_cfg();
    c.tone_length = COUNT_W'($urandom_range(3, 12));
    wait_idle();
    apply_cfg(c);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYC;
    repeat (40) send_tick($urandom_range(0, 15) == 0);
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (40) send_tick($urandom_range(0, 15) == 0);
  endtask

  // bulk of the run: random settings, random ticks, idling switched per phase
  task automatic test_random_sweep();
    cfg_t        c;
    int unsigned n;
    for (int ph = 0; ph < 20; ph++) begin
      c = random_cfg();
      wait_idle();
      apply_cfg(c);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      n = $urandom_range(50, 100);
      repeat (n) send_tick($urandom_range(0, 39) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall, frame check, watchdog
  // ---------------------------------------------------------------------------

  // hold-off first, then random stall runs when enabled
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (rx_idle_en && stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = rx_idle_en ? idle_len() : 0;
    end
  end

  // every frame beat against the oldest prediction
  always @(posedge clk) begin : frame_check
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("frame beat with no tick pending");
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (left_sample !== want.lsamp) begin
          $error("left_sample: expected %0d, got %0d", $signed(want.lsamp), left_sample);
          errors++;
        end
        if (right_sample !== want.rsamp) begin
          $error("right_sample: expected %0d, got %0d", $signed(want.rsamp), right_sample);
          errors++;
        end
        if (last !== want.eot) begin
          $error("last: expected %0d, got %0d", want.eot, last);
          errors++;
        end
      end
    end
  end

  // any beat on either side resets the quiet counter
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      sine_rom[k] = sine_entry(k);
    end
    cur_cfg    = '{WAVE_SINE, PHASE_STEP_RST, AMPLITUDE_RST, CHAN_MONO, TONE_LENGTH_RST};
    tone_phase = '0;
    frame_cnt  = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_waveform_shapes();
    test_tone_length_edges();
    test_backpressure();
    test_random_sweep();
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
